>>> src/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation codes and sequencer states of the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    // operand after a possible negation of the most negative value
    localparam int VAL_W  = OPERAND_WIDTH + 1;
    // exact product or sum of two products
    localparam int PROD_W = 2 * VAL_W;
    // magnitude of a product-width value
    localparam int MAG_W  = PROD_W - 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam int RES_W  = 33;
    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 3'd0,
        KIND_SUB    = 3'd1,
        KIND_MUL    = 3'd2,
        KIND_DIV    = 3'd3,
        KIND_CMP    = 3'd4,
        KIND_INC    = 3'd5,
        KIND_DEC    = 3'd6,
        KIND_TO_INT = 3'd7
    } kind_t;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_START = 11'b000_0000_0010,
        ST_MUL   = 11'b000_0000_0100,
        ST_RSET  = 11'b000_0000_1000,
        ST_GCD0  = 11'b000_0001_0000,
        ST_GCD1  = 11'b000_0010_0000,
        ST_GCD2  = 11'b000_0100_0000,
        ST_DIVN  = 11'b000_1000_0000,
        ST_DIVD  = 11'b001_0000_0000,
        ST_RDONE = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

endpackage

>>> src/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// From input transfer to m_valid: increment and compare skip reduction, to_int
// runs one division (none on a zero denominator); add, mul and dec reduce once
// (binary gcd plus two exact divisions); sub and div reduce b first as well.
// A stalled output adds its wait.
// Throughput: one transfer at a time; s_ready is high only when idle.
// Reset: aresetn (synchronous, active low) returns to idle, drops m_valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add/sub/mul/div, compare, increment, decrement, truncation to int;
// add/sub/mul/div/dec results reduced by a binary gcd and exact division.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [KIND_W-1:0]               s_kind,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_den,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [RES_W-1:0]         m_res_num,
    output logic signed [RES_W-1:0]         m_res_den,
    output logic                            m_less,
    output logic                            m_equal,
    output logic                            m_zero_den
);

    state_t                     state_reg, state_next;
    kind_t                      kind_reg, kind_next;
    logic signed [OPERAND_WIDTH-1:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [VAL_W-1:0]    vn_reg, vn_next, vd_reg, vd_next;
    logic signed [PROD_W-1:0]   rn_reg, rn_next, rd_reg, rd_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [MAG_W-1:0]           x_reg, x_next, y_reg, y_next;
    logic [MAG_W-1:0]           quo_reg, quo_next, rem_reg, rem_next;
    logic [CNT_W-1:0]           k_reg, k_next, cnt_reg, cnt_next;
    logic [1:0]                 step_reg, step_next;
    logic                       pre_reg, pre_next, neg_reg, neg_next;
    logic                       less_reg, less_next, equal_reg, equal_next;
    logic                       zd_reg, zd_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [RES_W-1:0]    m_res_num_reg, m_res_num_next;
    logic signed [RES_W-1:0]    m_res_den_reg, m_res_den_next;
    logic                       m_less_reg, m_less_next, m_equal_reg, m_equal_next;
    logic                       m_zero_den_reg, m_zero_den_next;

    // shared multiplier operands
    logic                       mulish;
    logic signed [VAL_W-1:0]    an_ext, ad_ext, op_a, op_b;
    logic signed [PROD_W-1:0]   prod;
    // reduction setup
    logic signed [PROD_W-1:0]   fix_num, fix_den, fix_mag, rn_mag, a_abs, d_abs;
    // divider step
    logic [MAG_W+1:0]           diff;
    logic                       borrow, div_last;
    logic [MAG_W-1:0]           q_final;

    assign an_ext = VAL_W'(an_reg);
    assign ad_ext = VAL_W'(ad_reg);
    assign mulish = (kind_reg == KIND_MUL) || (kind_reg == KIND_DIV);

    always_comb begin
        case (step_reg)
            2'd0: begin
                op_a = an_ext;
                op_b = mulish ? vn_reg : vd_reg;
            end
            2'd1: begin
                op_a = ad_ext;
                op_b = mulish ? vd_reg : vn_reg;
            end
            default: begin
                op_a = ad_ext;
                op_b = vd_reg;
            end
        endcase
    end

    assign prod = op_a * op_b;

    assign fix_num = rd_reg[PROD_W-1] ? -rn_reg : rn_reg;
    assign fix_den = rd_reg[PROD_W-1] ? -rd_reg : rd_reg;
    assign fix_mag = fix_num[PROD_W-1] ? -fix_num : fix_num;
    assign rn_mag  = neg_reg ? -rn_reg : rn_reg;
    assign a_abs   = an_reg[OPERAND_WIDTH-1] ? -PROD_W'(an_reg) : PROD_W'(an_reg);
    assign d_abs   = ad_reg[OPERAND_WIDTH-1] ? -PROD_W'(ad_reg) : PROD_W'(ad_reg);

    // restoring divider: one quotient bit per cycle, divisor in x_reg
    assign diff     = {1'b0, rem_reg, quo_reg[MAG_W-1]} - {2'b00, x_reg};
    assign borrow   = diff[MAG_W+1];
    assign q_final  = {quo_reg[MAG_W-2:0], ~borrow};
    assign div_last = (cnt_reg == CNT_W'(MAG_W - 1));

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        an_next         = an_reg;
        ad_next         = ad_reg;
        vn_next         = vn_reg;
        vd_next         = vd_reg;
        rn_next         = rn_reg;
        rd_next         = rd_reg;
        prod_next       = prod_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        pre_next        = pre_reg;
        neg_next        = neg_reg;
        less_next       = less_reg;
        equal_next      = equal_reg;
        zd_next         = zd_reg;
        m_valid_next    = m_valid_reg;
        m_res_num_next  = m_res_num_reg;
        m_res_den_next  = m_res_den_reg;
        m_less_next     = m_less_reg;
        m_equal_next    = m_equal_reg;
        m_zero_den_next = m_zero_den_reg;

        // drop the output once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = kind_t'(s_kind);
                    an_next    = s_a_num;
                    ad_next    = s_a_den;
                    vn_next    = VAL_W'(s_b_num);
                    vd_next    = VAL_W'(s_b_den);
                    less_next  = 1'b0;
                    equal_next = 1'b0;
                    zd_next    = 1'b0;
                    pre_next   = 1'b0;
                    step_next  = 2'd0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                case (kind_reg)
                    KIND_SUB: begin
                        rn_next    = -PROD_W'(vn_reg);
                        rd_next    = PROD_W'(vd_reg);
                        pre_next   = 1'b1;
                        state_next = ST_RSET;
                    end
                    KIND_DIV: begin
                        rn_next    = PROD_W'(vd_reg);
                        rd_next    = PROD_W'(vn_reg);
                        pre_next   = 1'b1;
                        state_next = ST_RSET;
                    end
                    KIND_INC: begin
                        rn_next    = PROD_W'(an_reg) + PROD_W'(ad_reg);
                        rd_next    = PROD_W'(ad_reg);
                        state_next = ST_DONE;
                    end
                    KIND_DEC: begin
                        rn_next    = PROD_W'(an_reg) - PROD_W'(ad_reg);
                        rd_next    = PROD_W'(ad_reg);
                        state_next = ST_RSET;
                    end
                    KIND_TO_INT: begin
                        rd_next = PROD_W'(1);
                        if (ad_reg == '0) begin
                            zd_next    = 1'b1;
                            rn_next    = '0;
                            state_next = ST_DONE;
                        end else begin
                            neg_next   = an_reg[OPERAND_WIDTH-1] ^ ad_reg[OPERAND_WIDTH-1];
                            quo_next   = a_abs[MAG_W-1:0];
                            x_next     = d_abs[MAG_W-1:0];
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_DIVN;
                        end
                    end
                    default: begin
                        step_next  = 2'd0;
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_MUL: begin
                prod_next = prod;
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0: begin
                    end
                    2'd1: begin
                        rn_next = prod_reg;
                        if (mulish) begin
                            // first product is the numerator; next is the den
                        end
                    end
                    2'd2: begin
                        if (kind_reg == KIND_CMP) begin
                            less_next  = rn_reg < prod_reg;
                            equal_next = (an_ext == vn_reg) && (ad_ext == vd_reg);
                            rn_next    = '0;
                            rd_next    = '0;
                            state_next = ST_DONE;
                        end else if (mulish) begin
                            rd_next    = prod_reg;
                            state_next = ST_RSET;
                        end else begin
                            rn_next = rn_reg + prod_reg;
                        end
                    end
                    default: begin
                        rd_next    = prod_reg;
                        state_next = ST_RSET;
                    end
                endcase
            end
            ST_RSET: begin
                if (rd_reg == '0) begin
                    state_next = ST_RDONE;
                end else if (fix_num == '0) begin
                    rn_next    = '0;
                    rd_next    = PROD_W'(1);
                    state_next = ST_RDONE;
                end else begin
                    rn_next    = fix_num;
                    rd_next    = fix_den;
                    neg_next   = fix_num[PROD_W-1];
                    x_next     = fix_mag[MAG_W-1:0];
                    y_next     = fix_den[MAG_W-1:0];
                    k_next     = '0;
                    state_next = ST_GCD0;
                end
            end
            ST_GCD0: begin
                // strip common factors of two
                if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + CNT_W'(1);
                end else begin
                    state_next = ST_GCD1;
                end
            end
            ST_GCD1: begin
                if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else begin
                    state_next = ST_GCD2;
                end
            end
            ST_GCD2: begin
                if (y_reg == '0) begin
                    x_next     = x_reg << k_reg;
                    quo_next   = rn_mag[MAG_W-1:0];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_reg > y_reg) begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end else begin
                    y_next = y_reg - x_reg;
                end
            end
            ST_DIVN, ST_DIVD: begin
                rem_next = borrow ? {rem_reg[MAG_W-2:0], quo_reg[MAG_W-1]}
                                  : diff[MAG_W-1:0];
                quo_next = q_final;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_last) begin
                    if (state_reg == ST_DIVN) begin
                        rn_next = neg_reg ? -signed'({1'b0, q_final})
                                          : signed'({1'b0, q_final});
                        if (kind_reg == KIND_TO_INT) begin
                            state_next = ST_DONE;
                        end else begin
                            quo_next   = rd_reg[MAG_W-1:0];
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_DIVD;
                        end
                    end else begin
                        rd_next    = signed'({1'b0, q_final});
                        state_next = ST_RDONE;
                    end
                end
            end
            ST_RDONE: begin
                if (pre_reg) begin
                    // reduced b operand feeds the main operation
                    vn_next    = rn_reg[VAL_W-1:0];
                    vd_next    = rd_reg[VAL_W-1:0];
                    pre_next   = 1'b0;
                    step_next  = 2'd0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_res_num_next  = RES_W'(rn_reg);
                    m_res_den_next  = RES_W'(rd_reg);
                    m_less_next     = less_reg;
                    m_equal_next    = equal_reg;
                    m_zero_den_next = zd_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg       <= kind_next;
        an_reg         <= an_next;
        ad_reg         <= ad_next;
        vn_reg         <= vn_next;
        vd_reg         <= vd_next;
        rn_reg         <= rn_next;
        rd_reg         <= rd_next;
        prod_reg       <= prod_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        k_reg          <= k_next;
        cnt_reg        <= cnt_next;
        step_reg       <= step_next;
        pre_reg        <= pre_next;
        neg_reg        <= neg_next;
        less_reg       <= less_next;
        equal_reg      <= equal_next;
        zd_reg         <= zd_next;
        m_res_num_reg  <= m_res_num_next;
        m_res_den_reg  <= m_res_den_next;
        m_less_reg     <= m_less_next;
        m_equal_reg    <= m_equal_next;
        m_zero_den_reg <= m_zero_den_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_res_num  = m_res_num_reg;
    assign m_res_den  = m_res_den_reg;
    assign m_less     = m_less_reg;
    assign m_equal    = m_equal_reg;
    assign m_zero_den = m_zero_den_reg;

endmodule

>>> src/rau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker
    import rau_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [RES_W-1:0] m_res_num,
    input logic signed [RES_W-1:0] m_res_den,
    input logic                    m_less,
    input logic                    m_equal,
    input logic                    m_zero_den
);

    // one item at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after an input transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_num) && $stable(m_res_den))
        else $error("stalled result changed");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_den |-> !m_less && !m_equal && m_res_num == '0
            && m_res_den == RES_W'(1))
        else $error("zero_den result malformed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_res_num  (m_res_num),
    .m_res_den  (m_res_den),
    .m_less     (m_less),
    .m_equal    (m_equal),
    .m_zero_den (m_zero_den)
);
